// ===== rtl/output_semantic_map_builder_core_assert.svh =====
// assertion macros for the output semantic map builder
// used at the end of the top level, expects a clk and rst in scope
`ifndef OUTPUT_SEMANTIC_MAP_BUILDER_CORE_ASSERT_SVH
`define OUTPUT_SEMANTIC_MAP_BUILDER_CORE_ASSERT_SVH

// same-cycle implication
`define OSMB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OSMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/osmb_pkg.sv =====
// shared types, constants and the kind table of the output semantic map builder
// no dependencies
`default_nettype none

package osmb_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int CNT_W     = $clog2(REG_COUNT + 1);
  localparam int CLK_W     = 25;

  localparam logic [31:0] SEM_EMPTY_WORD = 32'h1F1F1F1F;

  localparam logic [3:0] KIND_POSITION   = 4'd0;
  localparam logic [3:0] KIND_NORMALQUAT = 4'd1;
  localparam logic [3:0] KIND_COLOR      = 4'd2;
  localparam logic [3:0] KIND_TC0        = 4'd3;
  localparam logic [3:0] KIND_TC0W       = 4'd4;
  localparam logic [3:0] KIND_TC1        = 4'd5;
  localparam logic [3:0] KIND_TC2        = 4'd6;
  localparam logic [3:0] KIND_VIEW       = 4'd7;
  localparam logic [3:0] KIND_DUMMY      = 4'd8;

  localparam logic [CLK_W-1:0] CLK_POSITION = 25'h0000001;
  localparam logic [CLK_W-1:0] CLK_COLOR    = 25'h0000002;
  localparam logic [CLK_W-1:0] CLK_TC0      = 25'h0000100;
  localparam logic [CLK_W-1:0] CLK_TC1      = 25'h0000200;
  localparam logic [CLK_W-1:0] CLK_TC2      = 25'h0000400;
  localparam logic [CLK_W-1:0] CLK_TC0W     = 25'h0010000;
  localparam logic [CLK_W-1:0] CLK_QUATVIEW = 25'h1000000;

  typedef struct packed {
    logic [7:0]       base;
    logic [2:0]       max_comps;
    logic [CLK_W-1:0] clock;
    logic             texcoord;
  } kind_row_t;

  typedef struct packed {
    logic       first_entry;
    logic [3:0] reg_index;
    logic [3:0] kind;
    logic [3:0] component_mask;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]      register_semantics;
    logic [15:0]      used_register_mask;
    logic [4:0]       used_register_count;
    logic [CLK_W-1:0] clock_enable_mask;
    logic             uses_texcoords;
    logic             bad_kind;
  } out_beat_t;

  typedef struct packed {
    logic [REG_COUNT-1:0] used_mask;
    logic [CNT_W-1:0]     used_count;
  } status_t;

  function automatic kind_row_t kind_row(input logic [3:0] kind);
    kind_row_t row;
    row = '0;
    unique case (kind)
      KIND_POSITION:   row = '{base: 8'h00, max_comps: 3'd4, clock: '0,           texcoord: 1'b0};
      KIND_NORMALQUAT: row = '{base: 8'h04, max_comps: 3'd4, clock: CLK_QUATVIEW, texcoord: 1'b0};
      KIND_COLOR:      row = '{base: 8'h08, max_comps: 3'd4, clock: CLK_COLOR,    texcoord: 1'b0};
      KIND_TC0:        row = '{base: 8'h0C, max_comps: 3'd2, clock: CLK_TC0,      texcoord: 1'b1};
      KIND_TC0W:       row = '{base: 8'h10, max_comps: 3'd1, clock: CLK_TC0W,     texcoord: 1'b1};
      KIND_TC1:        row = '{base: 8'h0E, max_comps: 3'd2, clock: CLK_TC1,      texcoord: 1'b1};
      KIND_TC2:        row = '{base: 8'h16, max_comps: 3'd2, clock: CLK_TC2,      texcoord: 1'b1};
      KIND_VIEW:       row = '{base: 8'h12, max_comps: 3'd3, clock: CLK_QUATVIEW, texcoord: 1'b0};
      default:         row = '0;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/osmb_assign.sv =====
// semantic code assignment over the four components of one register
// depends on osmb_pkg for the kind table
`default_nettype none

module osmb_assign (
  input  wire logic [3:0]               kind,
  input  wire logic [3:0]               component_mask,
  input  wire logic [31:0]              base_word,
  output logic      [31:0]              word,
  output logic      [osmb_pkg::CLK_W-1:0] clock_set,
  output logic                          texcoord
);
  import osmb_pkg::*;

  kind_row_t row;

  always_comb begin
    logic [7:0] code;
    logic [2:0] assigned;
    logic       pos_clock;
    row       = kind_row(kind);
    code      = row.base;
    assigned  = 3'd0;
    pos_clock = 1'b0;
    word      = base_word;
    for (int c = 0; c < 4; c++) begin
      if (component_mask[c] && (assigned < row.max_comps)) begin
        word[c*8 +: 8] = code;
        code           = code + 8'd1;
        assigned       = assigned + 3'd1;
        // position needs clock bit 0 once its third code is placed
        if ((kind == KIND_POSITION) && (assigned == 3'd3)) begin
          pos_clock = 1'b1;
        end
      end
    end
    clock_set = row.clock | (pos_clock ? CLK_POSITION : '0);
    texcoord  = row.texcoord;
  end

endmodule

`default_nettype wire

// ===== rtl/osmb_map_state.sv =====
// accumulated map state: semantic entries, used set, count, clocks, texcoord flag
// depends on osmb_pkg and osmb_assign
`default_nettype none

module osmb_map_state (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire osmb_pkg::in_beat_t  beat,
  output osmb_pkg::out_beat_t      result,
  output osmb_pkg::status_t        status
);
  import osmb_pkg::*;

  logic [31:0]          sem_mem [REG_COUNT];
  logic [REG_COUNT-1:0] sem_valid;
  logic [REG_COUNT-1:0] used_mask;
  logic [CNT_W-1:0]     used_count;
  logic [CLK_W-1:0]     clock_bits;
  logic                 texcoord_seen;

  logic [REG_IDX_W-1:0] idx;
  logic                 in_range;
  logic                 bad;
  logic                 apply;
  logic [31:0]          cur_word;
  logic [31:0]          base_word;
  logic [31:0]          new_word;
  logic [CLK_W-1:0]     clock_set;
  logic                 tex_set;
  logic [REG_COUNT-1:0] reg_bit;
  logic [REG_COUNT-1:0] used_base;
  logic [CNT_W-1:0]     count_base;
  logic [REG_COUNT-1:0] used_mask_next;
  logic [CNT_W-1:0]     used_count_next;
  logic [CLK_W-1:0]     clock_bits_next;
  logic                 texcoord_seen_next;
  logic [REG_COUNT+15:0] mask_ext;
  logic [CNT_W+4:0]      count_ext;

  assign idx      = REG_IDX_W'(beat.reg_index);
  assign in_range = {2'b00, beat.reg_index} < 6'(REG_COUNT);
  assign bad      = beat.kind > KIND_DUMMY;
  assign apply    = !bad && in_range;

  assign cur_word  = sem_valid[idx] ? sem_mem[idx] : SEM_EMPTY_WORD;
  assign base_word = beat.first_entry ? SEM_EMPTY_WORD : cur_word;

  osmb_assign u_assign (
    .kind           (beat.kind),
    .component_mask (beat.component_mask),
    .base_word      (base_word),
    .word           (new_word),
    .clock_set      (clock_set),
    .texcoord       (tex_set)
  );

  always_comb begin
    reg_bit    = REG_COUNT'(1) << idx;
    used_base  = beat.first_entry ? '0 : used_mask;
    count_base = beat.first_entry ? '0 : used_count;
    used_mask_next  = used_base | reg_bit;
    used_count_next = ((used_base & reg_bit) == '0) ? count_base + CNT_W'(1) : count_base;
    clock_bits_next    = (beat.first_entry ? '0 : clock_bits) | clock_set;
    texcoord_seen_next = (beat.first_entry ? 1'b0 : texcoord_seen) | tex_set;
  end

  always_comb begin
    mask_ext  = {16'd0, (apply ? used_mask_next : used_mask)};
    count_ext = {5'd0, (apply ? used_count_next : used_count)};
    result.register_semantics  = in_range ? (apply ? new_word : cur_word) : 32'd0;
    result.used_register_mask  = mask_ext[15:0];
    result.used_register_count = count_ext[4:0];
    result.clock_enable_mask   = apply ? clock_bits_next : clock_bits;
    result.uses_texcoords      = apply ? texcoord_seen_next : texcoord_seen;
    result.bad_kind            = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sem_valid     <= '0;
      used_mask     <= '0;
      used_count    <= '0;
      clock_bits    <= '0;
      texcoord_seen <= 1'b0;
    end else if (fire && apply) begin
      sem_valid     <= (beat.first_entry ? '0 : sem_valid) | reg_bit;
      used_mask     <= used_mask_next;
      used_count    <= used_count_next;
      clock_bits    <= clock_bits_next;
      texcoord_seen <= texcoord_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && apply) begin
      sem_mem[idx] <= new_word;
    end
  end

  assign status.used_mask  = used_mask;
  assign status.used_count = used_count;

endmodule

`default_nettype wire

// ===== rtl/output_semantic_map_builder_core.sv =====
// a beat accepted into the input stage is registered there, and its result is loaded
// into the output register once the output is not stalled downstream
// throughput: one descriptor per cycle while not stalled downstream, state update and lookup done in one stage
// reset: synchronous rst empties both stages, clears the used set, count, clocks
// and texcoord flag, and marks every semantic entry empty (0x1F per byte)
// top level of the output semantic map builder, uses osmb_pkg and osmb_map_state
`default_nettype none

module output_semantic_map_builder_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                desc_valid,
  output logic                     desc_stall,
  input  wire osmb_pkg::in_beat_t  desc,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output osmb_pkg::out_beat_t      res
);
  import osmb_pkg::*;

  `include "output_semantic_map_builder_core_assert.svh"

  in_beat_t  st;
  logic      st_valid;
  logic      advance;
  logic      fire;
  out_beat_t result;
  status_t   status;

  assign advance    = !res_valid || !res_stall;
  assign desc_stall = st_valid && !advance;
  assign fire       = st_valid && advance;

  osmb_map_state u_state (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .beat   (st),
    .result (result),
    .status (status)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (!desc_stall) begin
      st_valid <= desc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && !desc_stall) begin
      st <= desc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= result;
    end
  end

  `OSMB_ASSERT_SAME(a_count_matches_set, 1'b1, status.used_count == CNT_W'($countones(status.used_mask)), "used count differs from used set")
  `OSMB_ASSERT_NEXT(a_fire_gives_result, fire, res_valid, "fired beat produced no result")
  `OSMB_ASSERT_SAME(a_stall_needs_full_stage, desc_stall, st_valid && res_valid, "stall raised with room in the pipe")

endmodule

`default_nettype wire
